[hw/rtl/qfts_pkg.sv]
package qfts_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_XFER,
    S_POP,
    S_POP_WAIT,
    S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_ENQ,
    CAP_EMPTY,
    CAP_POP
  } cap_sel_t;

  typedef struct packed {
    logic     push;
    logic     mv_rd;
    logic     pop_rd;
    cap_sel_t cap;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic in_full;
    logic in_zero;
    logic out_zero;
    logic mv_pend;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/qfts_ifs.sv]
interface qfts_in_if;
  import qfts_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink (input valid, input opcode, input push_value, output ready);
endinterface

interface qfts_out_if;
  import qfts_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [1:0]               status;
  logic                     queue_empty;

  modport source (output valid, output read_value, output status, output queue_empty,
                  input ready);
  modport sink (input valid, input read_value, input status, input queue_empty,
                output ready);
endinterface

[hw/rtl/queue_from_two_stacks_core.sv]
// FIFO queue of signed 32-bit words built from two bounded stacks.
// Input channel (in_chan): each word is an opcode and a push value. An enqueue
// pushes the value onto the input stack, or drops it with status 1 when that
// stack is full. A dequeue pops the output stack; when the output stack is
// empty, the whole input stack is first moved across, one entry per cycle.
// Result channel (out_chan): exactly one word per input word, in order:
// read value (-1 with status 2 on an empty queue, 0 on enqueue), status, and
// whether both stacks are empty afterward.
// Timing: one item is worked on at a time. An enqueue or an empty dequeue
// captures its result on acceptance, a dequeue that finds the output stack
// filled pops it via S_POP_WAIT, and one that triggers the transfer moves
// the entries in S_XFER, then pops via S_POP and S_POP_WAIT; the transfer is
// bounded by the input stack memory's one read per cycle. The next word is
// accepted as soon as the previous result sits in the output register.
// Reset (rst_n low, synchronous) empties both stacks and drops any pending
// result. When the receiver stalls, the result word holds and the block stops
// accepting once the next result is ready behind it.
module queue_from_two_stacks_core
  import qfts_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  qfts_in_if.sink   in_chan,
  qfts_out_if.source out_chan
);

  cmd_t cmd;
  sts_t sts;

  qfts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_opcode (in_chan.opcode),
    .in_ready  (in_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  qfts_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_value  (in_chan.push_value),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_chan.ready),
    .out_valid   (out_chan.valid),
    .read_value  (out_chan.read_value),
    .status      (out_chan.status),
    .queue_empty (out_chan.queue_empty)
  );

endmodule

[hw/rtl/qfts_ram.sv]
module qfts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/qfts_ctrl.sv]
module qfts_ctrl
  import qfts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_opcode,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '{push: 1'b0, mv_rd: 1'b0, pop_rd: 1'b0, cap: CAP_NONE, load_out: 1'b0};
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == OP_ENQ) begin
            cmd.push  = !sts.in_full;
            cmd.cap   = CAP_ENQ;
            state_nxt = S_RESULT;
          end else if (sts.in_zero && sts.out_zero) begin
            cmd.cap   = CAP_EMPTY;
            state_nxt = S_RESULT;
          end else if (!sts.out_zero) begin
            cmd.pop_rd = 1'b1;
            state_nxt  = S_POP_WAIT;
          end else begin
            state_nxt = S_XFER;
          end
        end
      end
      // One entry leaves the input stack per cycle; its write into the output
      // stack waits for the registered read data (mv_pend), so wait for the last one before popping.
      S_XFER: begin
        if (!sts.in_zero) begin
          cmd.mv_rd = 1'b1;
        end else if (!sts.mv_pend) begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        cmd.pop_rd = 1'b1;
        state_nxt  = S_POP_WAIT;
      end
      S_POP_WAIT: begin
        cmd.cap   = CAP_POP;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/qfts_dp.sv]
module qfts_dp
  import qfts_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [DATA_W-1:0] push_value,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] read_value,
  output logic [1:0]               status,
  output logic                     queue_empty
);

  logic [CNT_W-1:0]  in_cnt_r, in_cnt_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [CNT_W-1:0]  in_top, out_top;
  logic              mv_pend_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] in_rdata, out_rdata;
  logic [DATA_W-1:0] res_value_r;
  logic [1:0]        res_status_r;
  logic              res_empty_r;
  logic [DATA_W-1:0] out_value_r;
  logic [1:0]        out_status_r;
  logic              out_empty_r;
  logic              in_zero, out_zero, in_full, out_full;

  assign in_top   = in_cnt_r - CNT_W'(1);
  assign out_top  = out_cnt_r - CNT_W'(1);
  assign in_zero  = (in_cnt_r == '0);
  assign out_zero = (out_cnt_r == '0);
  assign in_full  = (in_cnt_r == CNT_W'(STACK_DEPTH));
  assign out_full = (out_cnt_r == CNT_W'(STACK_DEPTH));

  qfts_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_in_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (in_cnt_r[PTR_W-1:0]),
    .wdata (push_value),
    .re    (cmd.mv_rd),
    .raddr (in_top[PTR_W-1:0]),
    .rdata (in_rdata)
  );

  // A word read from the input stack is written to the output stack in the
  // next cycle, when the registered read data is available.
  qfts_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_out_ram (
    .clk   (clk),
    .we    (mv_pend_r),
    .waddr (out_cnt_r[PTR_W-1:0]),
    .wdata (in_rdata),
    .re    (cmd.pop_rd),
    .raddr (out_top[PTR_W-1:0]),
    .rdata (out_rdata)
  );

  always_comb begin
    in_cnt_nxt  = in_cnt_r;
    out_cnt_nxt = out_cnt_r;
    if (cmd.push) begin
      in_cnt_nxt = in_cnt_r + CNT_W'(1);
    end else if (cmd.mv_rd) begin
      in_cnt_nxt = in_top;
    end
    if (mv_pend_r) begin
      out_cnt_nxt = out_cnt_r + CNT_W'(1);
    end else if (cmd.pop_rd) begin
      out_cnt_nxt = out_top;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r    <= '0;
      out_cnt_r   <= '0;
      mv_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_cnt_r  <= in_cnt_nxt;
      out_cnt_r <= out_cnt_nxt;
      mv_pend_r <= cmd.mv_rd;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.cap)
      CAP_ENQ: begin
        res_value_r  <= '0;
        res_status_r <= in_full ? STAT_FULL : STAT_OK;
        res_empty_r  <= 1'b0;
      end
      CAP_EMPTY: begin
        res_value_r  <= EMPTY_VALUE;
        res_status_r <= STAT_EMPTY;
        res_empty_r  <= 1'b1;
      end
      CAP_POP: begin
        res_value_r  <= out_rdata;
        res_status_r <= STAT_OK;
        res_empty_r  <= in_zero && out_zero;
      end
      default: begin
      end
    endcase
    if (cmd.load_out) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
      out_empty_r  <= res_empty_r;
    end
  end

  assign sts.in_full  = in_full;
  assign sts.in_zero  = in_zero;
  assign sts.out_zero = out_zero;
  assign sts.mv_pend  = mv_pend_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign read_value  = out_value_r;
  assign status      = out_status_r;
  assign queue_empty = out_empty_r;

  a_move_fits: assert property (@(posedge clk) disable iff (!rst_n)
    mv_pend_r |-> !out_full)
    else $error("transfer write into a full output stack");

  a_move_src: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mv_rd |-> !in_zero && out_cnt_r == '0 || cmd.mv_rd && !in_zero && mv_pend_r)
    else $error("transfer read from an empty input stack or onto a filled output stack");

  a_pop_src: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_rd |-> !out_zero && !mv_pend_r)
    else $error("pop of an empty output stack");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_value_r) && $stable(out_status_r))
    else $error("pending result word overwritten");

endmodule
